@@ rtl/core/kwm_pkg.sv @@
// ---------------------------------------------------------------------------
// kwm_pkg
// Shared types, constants and helpers of the k-mer window minimizer.
// ---------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

   localparam int WINDOW  = 7;
   localparam int KMAX    = 15;
   localparam int CODE_W  = 2 * KMAX;
   localparam int K_W     = 4;
   localparam int SEEN_W  = $clog2(KMAX + WINDOW + 2);
   localparam int LVLS    = $clog2(WINDOW);
   localparam int WPOW    = 1 << LVLS;
   localparam int AGE_W   = LVLS;
   localparam int CNT_W   = 32;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);

   localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(KMAX + WINDOW);

   localparam logic [1:0] KIND_SHIFT = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_SLIDE = 2'd2;

   typedef struct packed {
      logic              new_read;
      logic [1:0]        kind;
      logic [CODE_W-1:0] code;
   } kwm_item_type;

   function automatic logic [CODE_W-1:0] kmer_mask(input logic [K_W-1:0] k);
      logic [5:0] sh;
      sh = 6'(CODE_W) - {1'b0, k, 1'b0};
      return {CODE_W{1'b1}} >> sh;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/kwm_front.sv @@
// ---------------------------------------------------------------------------
// kwm_front
// Accepts bases, keeps the rolling k-mer code and read position, and
// classifies each complete k-mer for the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module kwm_front import kwm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [K_W-1:0]     csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_base_code,
   input  wire logic               req_start_of_read,
   input  wire logic               q_full,
   output logic                    q_push,
   output kwm_item_type            q_item
);

   logic [K_W-1:0]    kmer_len_ff;
   logic [K_W-1:0]    kmer_len_in;
   logic [CODE_W-1:0] rolling_ff;
   logic [CODE_W-1:0] rolling_in;
   logic [SEEN_W-1:0] seen_ff;
   logic [SEEN_W-1:0] seen_in;
   logic              pend_ff;
   logic              pend_in;

   logic              accept;
   logic [K_W-1:0]    k_eff;
   logic [CODE_W-1:0] rc_base;
   logic [SEEN_W-1:0] seen_base;
   logic [SEEN_W-1:0] cnt;
   logic [SEEN_W-1:0] fill;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      k_eff       = (kmer_len_ff == '0) ? K_W'(1) : kmer_len_ff;
      fill        = SEEN_W'(k_eff) + SEEN_W'(WINDOW - 1);
      rc_base     = req_start_of_read ? '0 : rolling_ff;
      seen_base   = req_start_of_read ? '0 : seen_ff;
      cnt         = seen_base + SEEN_W'(1);
      kmer_len_in = csr_wr_en ? csr_wr_data : kmer_len_ff;

      rolling_in = rolling_ff;
      seen_in    = seen_ff;
      if (accept) begin
         rolling_in = {rc_base[CODE_W-3:0], req_base_code} & kmer_mask(k_eff);
         seen_in    = (seen_base < SEEN_MAX) ? cnt : seen_base;
      end

      q_push = accept && (cnt >= SEEN_W'(k_eff));
      q_item.new_read = req_start_of_read || pend_ff;
      q_item.code     = rolling_in;
      if (cnt < fill) begin
         q_item.kind = KIND_SHIFT;
      end else if (cnt == fill) begin
         q_item.kind = KIND_FILL;
      end else begin
         q_item.kind = KIND_SLIDE;
      end

      // hold a start flag until the next k-mer carries it
      pend_in = pend_ff;
      if (q_push) begin
         pend_in = 1'b0;
      end else if (accept && req_start_of_read) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_len_ff <= K_W'(KMAX);
         rolling_ff  <= '0;
         seen_ff     <= '0;
         pend_ff     <= 1'b0;
      end else begin
         kmer_len_ff <= kmer_len_in;
         rolling_ff  <= rolling_in;
         seen_ff     <= seen_in;
         pend_ff     <= pend_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/kwm_queue.sv @@
// ---------------------------------------------------------------------------
// kwm_queue
// Short FIFO of classified k-mers between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module kwm_queue import kwm_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  kwm_item_type      push_item,
   input  wire logic         pop,
   output logic              head_valid,
   output kwm_item_type      head_item,
   output logic              full
);

   kwm_item_type        slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/kwm_back.sv @@
// ---------------------------------------------------------------------------
// kwm_back
// Holds the k-mer window, tracks the current minimum, rescans through a
// compare tree and registers each minimizer for the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module kwm_back import kwm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  kwm_item_type            head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CODE_W-1:0]       rsp_minimizer_value,
   output logic [CNT_W-1:0]        rsp_minimizer_ordinal
);

   logic [CODE_W-1:0] win_ff [WINDOW];
   logic [CODE_W-1:0] win_in [WINDOW];
   logic [CODE_W-1:0] min_ff;
   logic [CODE_W-1:0] min_in;
   logic [AGE_W-1:0]  age_ff;
   logic [AGE_W-1:0]  age_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              valid_ff;
   logic              valid_in;
   logic [CODE_W-1:0] value_ff;
   logic [CODE_W-1:0] value_in;
   logic [CNT_W-1:0]  ordinal_ff;
   logic [CNT_W-1:0]  ordinal_in;

   logic [CODE_W-1:0] tv [WPOW];
   logic [LVLS-1:0]   ti [WPOW];
   logic [CODE_W-1:0] min_base;
   logic [AGE_W-1:0]  age_base;
   logic [CNT_W-1:0]  cnt_base;
   logic [CNT_W-1:0]  cnt_next;
   logic              emit;

   assign pop                   = head_valid && (!valid_ff || rsp_ready);
   assign rsp_valid             = valid_ff;
   assign rsp_minimizer_value   = value_ff;
   assign rsp_minimizer_ordinal = ordinal_ff;

   always_comb begin
      for (int i = 0; i < WINDOW - 1; i++) begin
         win_in[i] = pop ? win_ff[i+1] : win_ff[i];
      end
      win_in[WINDOW-1] = pop ? head_item.code : win_ff[WINDOW-1];

      // earliest minimum of the shifted window, left wins on ties
      for (int i = 0; i < WPOW; i++) begin
         tv[i] = {CODE_W{1'b1}};
         ti[i] = LVLS'(i);
      end
      for (int i = 0; i < WINDOW; i++) begin
         tv[i] = win_in[i];
      end
      for (int l = 0; l < LVLS; l++) begin
         for (int i = 0; i < WPOW / 2; i++) begin
            if (i < (WPOW >> (l + 1))) begin
               if (tv[2*i+1] < tv[2*i]) begin
                  tv[i] = tv[2*i+1];
                  ti[i] = ti[2*i+1];
               end else begin
                  tv[i] = tv[2*i];
                  ti[i] = ti[2*i];
               end
            end
         end
      end

      min_base = head_item.new_read ? {CODE_W{1'b1}} : min_ff;
      age_base = head_item.new_read ? '0 : age_ff;
      cnt_base = head_item.new_read ? '0 : count_ff;
      cnt_next = (cnt_base == {CNT_W{1'b1}}) ? cnt_base : cnt_base + CNT_W'(1);

      emit   = 1'b0;
      min_in = min_base;
      age_in = age_base;
      case (head_item.kind)
         KIND_SHIFT: begin
            emit = 1'b0;
         end
         KIND_FILL: begin
            emit   = 1'b1;
            min_in = tv[0];
            age_in = ti[0];
         end
         KIND_SLIDE: begin
            if (age_base == '0) begin
               emit   = 1'b1;
               min_in = tv[0];
               age_in = ti[0];
            end else if (head_item.code < min_base) begin
               emit   = 1'b1;
               min_in = head_item.code;
               age_in = AGE_W'(WINDOW - 1);
            end else begin
               age_in = age_base - AGE_W'(1);
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      count_in = emit ? cnt_next : cnt_base;
      if (!pop) begin
         emit     = 1'b0;
         min_in   = min_ff;
         age_in   = age_ff;
         count_in = count_ff;
      end

      valid_in   = emit || (valid_ff && !rsp_ready);
      value_in   = emit ? min_in : value_ff;
      ordinal_in = emit ? count_in : ordinal_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW; i++) begin
         win_ff[i] <= win_in[i];
      end
      value_ff   <= value_in;
      ordinal_ff <= ordinal_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= {CODE_W{1'b1}};
         age_ff   <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         min_ff   <= min_in;
         age_ff   <= age_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("kwm_back: pop without queued item");

   a_fill_emits: assert property (@(posedge clock) disable iff (reset)
      (pop && head_item.kind == KIND_FILL) |=> (valid_ff && ordinal_ff != '0))
      else $error("kwm_back: window fill produced no minimizer");

   a_age_range: assert property (@(posedge clock) disable iff (reset)
      age_ff <= AGE_W'(WINDOW - 1))
      else $error("kwm_back: minimum age outside window");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(value_ff) && $stable(ordinal_ff)))
      else $error("kwm_back: pending minimizer overwritten");

endmodule

`default_nettype wire

@@ rtl/core/kmer_window_minimizer.sv @@
// ---------------------------------------------------------------------------
// kmer_window_minimizer
// Sliding-window k-mer minimizer over a stream of 2-bit base codes.
//
//   channel   ports                                  direction
//   req       req_valid/ready, base_code, start      in, one base per transfer
//   rsp       rsp_valid/ready, value, ordinal        out, one minimizer
//   csr       csr_wr_en, csr_wr_data                 in, kmer_len write
//
// One base per cycle unless the queue is full; a minimizer crosses the queue
// and output register. The window rescan is a registered-output compare tree.
// A four-entry queue between front and back absorbs result-side stalls;
// req_ready drops only when it is full. Synchronous reset sets kmer_len to 15.
// ---------------------------------------------------------------------------
`default_nettype none

module kmer_window_minimizer import kwm_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [K_W-1:0]     csr_wr_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_base_code,
   input  wire logic               req_start_of_read,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CODE_W-1:0]       rsp_minimizer_value,
   output logic [CNT_W-1:0]        rsp_minimizer_ordinal
);

   logic         q_push;
   logic         q_pop;
   logic         q_full;
   logic         q_head_valid;
   kwm_item_type q_push_item;
   kwm_item_type q_head_item;

   kwm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base_code     (req_base_code),
      .req_start_of_read (req_start_of_read),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_item            (q_push_item)
   );

   kwm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .full       (q_full)
   );

   kwm_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_valid            (q_head_valid),
      .head_item             (q_head_item),
      .pop                   (q_pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_minimizer_value   (rsp_minimizer_value),
      .rsp_minimizer_ordinal (rsp_minimizer_ordinal)
   );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// kmer_window_minimizer testbench
// Streams reads of 2-bit bases through the minimizer under several k-mer
// lengths and handshake pressure settings. A scoreboard class tracks the
// rolling k-mer, the seven-entry window and the running minimum, predicts
// each minimizer transfer, and compares value and ordinal in arrival order.
// ---------------------------------------------------------------------------

import kwm_pkg::*;

typedef struct packed {
   logic [CODE_W-1:0] value;
   logic [CNT_W-1:0]  ordinal;
} minimizer_type;

class minimizer_scoreboard;
   logic [K_W-1:0]    kmer_len;
   logic [CODE_W-1:0] rolling_code;
   logic [CODE_W-1:0] window_codes [WINDOW];
   logic [CODE_W-1:0] min_code;
   int unsigned       min_slot;
   int unsigned       bases_in_read;
   int unsigned       slots_written;
   logic [CNT_W-1:0]  read_ordinal;
   minimizer_type     due_minimizers [$];
   int                mismatches;

   function new();
      kmer_len = K_W'(KMAX);
      slots_written = 0;
      mismatches = 0;
      clear_read();
   endfunction

   function void clear_read();
      rolling_code = '0;
      bases_in_read = 0;
      min_code = '1;
      min_slot = 0;
      read_ordinal = '0;
   endfunction

   function void post_minimizer();
      minimizer_type m;
      if (read_ordinal != '1) read_ordinal++;
      m.value = min_code;
      m.ordinal = read_ordinal;
      due_minimizers.push_back(m);
   endfunction

   function void take_base(input logic [1:0] base, input logic first);
      int unsigned k;
      int unsigned fill;
      int unsigned prev;
      int unsigned j;
      logic [CODE_W-1:0] kmask;
      k = (kmer_len == 0) ? 1 : int'(kmer_len);
      kmask = {CODE_W{1'b1}} >> (CODE_W - 2 * k);
      fill = k + WINDOW - 1;
      if (first) clear_read();
      rolling_code = ((rolling_code << 2) | CODE_W'(base)) & kmask;
      prev = bases_in_read;
      if (bases_in_read < KMAX + WINDOW) bases_in_read++;
      if (prev + 1 < k) return;
      for (j = 0; j + 1 < WINDOW; j++) window_codes[j] = window_codes[j + 1];
      window_codes[WINDOW - 1] = rolling_code;
      if (slots_written < WINDOW) slots_written++;
      if (prev + 1 < fill) return;
      if (prev + 1 == fill || min_slot == 0) begin
         min_code = window_codes[0];
         min_slot = 0;
         for (j = 1; j < WINDOW; j++) begin
            if (window_codes[j] < min_code) begin
               min_code = window_codes[j];
               min_slot = j;
            end
         end
         post_minimizer();
         return;
      end
      min_slot--;
      if (rolling_code < min_code) begin
         min_code = rolling_code;
         min_slot = WINDOW - 1;
         post_minimizer();
      end
   endfunction

   function void match_minimizer(input logic [CODE_W-1:0] value,
                                 input logic [CNT_W-1:0] ordinal);
      minimizer_type want;
      if (due_minimizers.size() == 0) begin
         $display("%0t: unexpected minimizer, value %h ordinal %0d", $time, value, ordinal);
         mismatches++;
         return;
      end
      want = due_minimizers.pop_front();
      if (value !== want.value) begin
         $display("%0t: minimizer_value expected %h actual %h", $time, want.value, value);
         mismatches++;
      end
      if (ordinal !== want.ordinal) begin
         $display("%0t: minimizer_ordinal expected %0d actual %0d",
                  $time, want.ordinal, ordinal);
         mismatches++;
      end
   endfunction

   function int pending();
      return due_minimizers.size();
   endfunction
endclass

module testbench;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   localparam int STYLE_RANDOM = 0;
   localparam int STYLE_ALL_T  = 1;
   localparam int STYLE_ALL_A  = 2;
   localparam int STYLE_MOSTLY = 3;

   localparam int PHASES       = 8;
   localparam int PHASE_BASES  = 200;
   localparam int SETTLE       = 12;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [K_W-1:0]     csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_base_code = BASE_A;
   logic               req_start_of_read = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CODE_W-1:0]  rsp_minimizer_value;
   logic [CNT_W-1:0]   rsp_minimizer_ordinal;

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned kmer_setting = KMAX;
   int unsigned read_left = 0;
   int          read_style = STYLE_RANDOM;
   logic        force_start = 1'b1;

   minimizer_scoreboard sb = new();

   kmer_window_minimizer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_base_code         (req_base_code),
      .req_start_of_read     (req_start_of_read),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_minimizer_value   (rsp_minimizer_value),
      .rsp_minimizer_ordinal (rsp_minimizer_ordinal)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.match_minimizer(rsp_minimizer_value, rsp_minimizer_ordinal);
      end
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_base(input logic [1:0] base, input logic first);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base_code <= base;
      req_start_of_read <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_base(base, first);
      @(negedge clock);
   endtask

   task automatic write_kmer_len(input logic [K_W-1:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.kmer_len = len;
      kmer_setting = (len == 0) ? 1 : len;
      // hold back a read that would continue onto a window never written
      if (sb.slots_written < WINDOW) force_start = 1'b1;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic stream_reads(input int count);
      int          fill;
      int unsigned pick;
      logic [1:0]  base;
      logic        first;
      repeat (count) begin
         fill = kmer_setting + WINDOW - 1;
         first = 1'b0;
         if (read_left == 0 || force_start) begin
            first = 1'b1;
            force_start = 1'b0;
            pick = $urandom_range(99);
            if (pick < 15)      read_left = $urandom_range(fill - 1, 1);
            else if (pick < 25) read_left = fill;
            else if (pick < 90) read_left = $urandom_range(fill + 30, fill);
            else                read_left = $urandom_range(fill + 120, fill + 30);
            pick = $urandom_range(99);
            if (pick < 60)      read_style = STYLE_RANDOM;
            else if (pick < 70) read_style = STYLE_ALL_T;
            else if (pick < 80) read_style = STYLE_ALL_A;
            else                read_style = STYLE_MOSTLY;
         end
         case (read_style)
            STYLE_ALL_T: base = BASE_T;
            STYLE_ALL_A: base = BASE_A;
            STYLE_MOSTLY: base = ($urandom_range(99) < 85) ? BASE_T : 2'($urandom_range(3));
            default: base = 2'($urandom_range(3));
         endcase
         read_left--;
         send_base(base, first);
      end
   endtask

   initial begin
      int unsigned k_plan [PHASES];
      int          p;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero length acts as one: window fills after seven bases
      write_kmer_len(K_W'(0));
      send_base(BASE_T, 1'b1);
      repeat (2) send_base(BASE_T, 1'b0);
      send_base(BASE_T, 1'b1);
      repeat (6) send_base(BASE_T, 1'b0);
      send_base(BASE_A, 1'b0);
      repeat (6) send_base(BASE_G, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_C, 1'b1);
      send_base(BASE_G, 1'b1);
      drain_results();

      k_plan = '{KMAX, 1, 0, $urandom_range(14, 2), 1, KMAX, $urandom_range(14, 2), KMAX};
      for (p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 68; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 68; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         write_kmer_len(K_W'(k_plan[p]));
         stream_reads(PHASE_BASES);
         drain_results();
      end

      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/kwm_pkg.sv
rtl/core/kwm_front.sv
rtl/core/kwm_queue.sv
rtl/core/kwm_back.sv
rtl/core/kmer_window_minimizer.sv
dv/testbench.sv
